// ===== src/pip_pkg.sv =====
package pip_pkg;

   localparam int POLYGONS_DEFAULT     = 16;
   localparam int MAX_VERTICES_DEFAULT = 64;
   localparam int COORD_WIDTH_DEFAULT  = 32;

   localparam int POLY_ID_WIDTH      = 4;
   localparam int VERTEX_INDEX_WIDTH = 6;
   localparam int VERTEX_COUNT_WIDTH = 7;
   localparam int COORD_PORT_WIDTH   = 32;

   localparam int DRAIN_CYCLES = 3;

   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_QUERY = 1'b1
   } command_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SETUP,
      ST_WALK,
      ST_DRAIN,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic capture;
      logic load_write;
      logic rd_en;
      logic rd_prime;
      logic clear_inside;
   } ctrl_cmd_type;

   typedef struct packed {
      logic empty;
   } ctrl_stat_type;

endpackage

// ===== src/pip_ram.sv =====
module pip_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== src/pip_ctrl.sv =====
module pip_ctrl #(
   parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEFAULT,
   localparam int VW = $clog2(MAX_VERTICES),
   localparam int CNTW = $clog2(MAX_VERTICES + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  pip_pkg::command_type   command,
   input  pip_pkg::ctrl_stat_type stat,
   input  logic [CNTW-1:0]        count,
   output pip_pkg::ctrl_cmd_type  cmd,
   output logic [VW-1:0]          rd_index,
   output logic                   busy,
   output logic                   rsp_strobe
);

   localparam int DRW = (pip_pkg::DRAIN_CYCLES > 1) ? $clog2(pip_pkg::DRAIN_CYCLES) : 1;

   pip_pkg::state_type state_ff, state_in;
   logic [VW-1:0]      idx_ff, idx_in;
   logic [DRW-1:0]     drain_ff, drain_in;
   logic               last_vertex;

   assign last_vertex = (CNTW'(idx_ff) == (count - CNTW'(1)));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pip_pkg::ST_IDLE: begin
            if (start) begin
               state_in = (command == pip_pkg::CMD_QUERY) ? pip_pkg::ST_SETUP
                                                          : pip_pkg::ST_LOAD;
            end
         end
         pip_pkg::ST_LOAD: begin
            state_in = pip_pkg::ST_IDLE;
         end
         pip_pkg::ST_SETUP: begin
            state_in = stat.empty ? pip_pkg::ST_RESPOND : pip_pkg::ST_WALK;
         end
         pip_pkg::ST_WALK: begin
            if (last_vertex) begin
               state_in = pip_pkg::ST_DRAIN;
            end
         end
         pip_pkg::ST_DRAIN: begin
            if (drain_ff == DRW'(pip_pkg::DRAIN_CYCLES - 1)) begin
               state_in = pip_pkg::ST_RESPOND;
            end
         end
         pip_pkg::ST_RESPOND: begin
            state_in = pip_pkg::ST_IDLE;
         end
         default: begin
            state_in = pip_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      rd_index   = idx_ff;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      idx_in     = idx_ff;
      drain_in   = '0;
      unique case (state_ff)
         pip_pkg::ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         pip_pkg::ST_LOAD: begin
            cmd.load_write = 1'b1;
         end
         pip_pkg::ST_SETUP: begin
            cmd.clear_inside = 1'b1;
            cmd.rd_en        = !stat.empty;
            cmd.rd_prime     = 1'b1;
            rd_index         = VW'(count - CNTW'(1));
            idx_in           = '0;
         end
         pip_pkg::ST_WALK: begin
            cmd.rd_en = 1'b1;
            idx_in    = idx_ff + VW'(1);
         end
         pip_pkg::ST_DRAIN: begin
            drain_in = drain_ff + DRW'(1);
         end
         pip_pkg::ST_RESPOND: begin
            rsp_strobe = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pip_pkg::ST_IDLE;
         idx_ff   <= '0;
         drain_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         drain_ff <= drain_in;
      end
   end

endmodule

// ===== src/pip_datapath.sv =====
module pip_datapath #(
   parameter int POLYGONS     = pip_pkg::POLYGONS_DEFAULT,
   parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEFAULT,
   parameter int COORD_WIDTH  = pip_pkg::COORD_WIDTH_DEFAULT,
   localparam int VW = $clog2(MAX_VERTICES),
   localparam int CNTW = $clog2(MAX_VERTICES + 1)
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [pip_pkg::POLY_ID_WIDTH-1:0]      req_polygon_id,
   input  logic [pip_pkg::VERTEX_INDEX_WIDTH-1:0] req_vertex_index,
   input  logic [pip_pkg::VERTEX_COUNT_WIDTH-1:0] req_vertex_count,
   input  logic [pip_pkg::COORD_PORT_WIDTH-1:0]   req_coord_x,
   input  logic [pip_pkg::COORD_PORT_WIDTH-1:0]   req_coord_y,
   input  pip_pkg::ctrl_cmd_type                  cmd,
   input  logic [VW-1:0]                          rd_index,
   output pip_pkg::ctrl_stat_type                 stat,
   output logic [CNTW-1:0]                        count,
   output logic                                   rsp_inside_res,
   output logic [pip_pkg::POLY_ID_WIDTH-1:0]      rsp_tested_polygon
);

   localparam int CW = (COORD_WIDTH < pip_pkg::COORD_PORT_WIDTH) ? COORD_WIDTH
                                                                 : pip_pkg::COORD_PORT_WIDTH;
   localparam int DW = CW + 1;
   localparam int PRW = 2 * DW;
   localparam int PW = (POLYGONS > 1) ? $clog2(POLYGONS) : 1;
   localparam int DEPTH = POLYGONS * MAX_VERTICES;
   localparam int AW = $clog2(DEPTH);

   logic [pip_pkg::POLY_ID_WIDTH-1:0]      poly_ff;
   logic [pip_pkg::VERTEX_INDEX_WIDTH-1:0] vidx_ff;
   logic [pip_pkg::VERTEX_COUNT_WIDTH-1:0] vcnt_ff;
   logic signed [CW-1:0]                   px_ff, py_ff;

   logic [CNTW-1:0] sizes_ff [POLYGONS];
   logic [PW-1:0]   poly_idx;
   logic            poly_ok, vidx_ok;
   logic [CNTW-1:0] cnt_clamp;
   logic [AW-1:0]   base, wr_addr, rd_addr;
   logic            vtx_write;

   logic [CW-1:0]        x_rd_raw, y_rd_raw;
   logic signed [CW-1:0] x_rd, y_rd;
   logic signed [CW-1:0] xj_ff, yj_ff;
   logic                 rdv_ff, prime_ff;

   logic                 av_ff, straddle_a_ff, dypos_a_ff;
   logic signed [DW-1:0] dxp_ff, dy_ff, dxe_ff, dyp_ff;
   logic signed [DW-1:0] dxp_in, dy_in, dxe_in, dyp_in;
   logic                 straddle_in;

   logic                  bv_ff, straddle_b_ff, dypos_b_ff;
   logic signed [PRW-1:0] prod_p_ff, prod_q_ff;
   logic                  toggle;
   logic                  inside_ff;

   assign poly_idx  = PW'(poly_ff);
   assign poly_ok   = (32'(poly_ff) < POLYGONS);
   assign vidx_ok   = (32'(vidx_ff) < MAX_VERTICES);
   assign cnt_clamp = (32'(vcnt_ff) > MAX_VERTICES) ? CNTW'(MAX_VERTICES) : CNTW'(vcnt_ff);
   assign count     = poly_ok ? sizes_ff[poly_idx] : '0;
   assign stat.empty = (count == '0);

   assign base      = AW'(32'(poly_idx) * MAX_VERTICES);
   assign wr_addr   = base + AW'(vidx_ff);
   assign rd_addr   = base + AW'(rd_index);
   assign vtx_write = cmd.load_write && poly_ok && vidx_ok;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         poly_ff <= req_polygon_id;
         vidx_ff <= req_vertex_index;
         vcnt_ff <= req_vertex_count;
         px_ff   <= req_coord_x[CW-1:0];
         py_ff   <= req_coord_y[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < POLYGONS; p++) begin
            sizes_ff[p] <= '0;
         end
      end else if (cmd.load_write && poly_ok) begin
         sizes_ff[poly_idx] <= cnt_clamp;
      end
   end

   pip_ram #(
      .WIDTH (CW),
      .DEPTH (DEPTH)
   ) u_x_store (
      .clock   (clock),
      .wr_en   (vtx_write),
      .wr_addr (wr_addr),
      .wr_data (px_ff),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (x_rd_raw)
   );

   pip_ram #(
      .WIDTH (CW),
      .DEPTH (DEPTH)
   ) u_y_store (
      .clock   (clock),
      .wr_en   (vtx_write),
      .wr_addr (wr_addr),
      .wr_data (py_ff),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (y_rd_raw)
   );

   assign x_rd = x_rd_raw;
   assign y_rd = y_rd_raw;

   assign straddle_in = (y_rd > py_ff) != (yj_ff > py_ff);
   assign dxp_in = {px_ff[CW-1], px_ff} - {x_rd[CW-1], x_rd};
   assign dy_in  = {yj_ff[CW-1], yj_ff} - {y_rd[CW-1], y_rd};
   assign dxe_in = {xj_ff[CW-1], xj_ff} - {x_rd[CW-1], x_rd};
   assign dyp_in = {py_ff[CW-1], py_ff} - {y_rd[CW-1], y_rd};

   always_ff @(posedge clock) begin
      if (reset) begin
         rdv_ff <= 1'b0;
         av_ff  <= 1'b0;
         bv_ff  <= 1'b0;
      end else begin
         rdv_ff <= cmd.rd_en;
         av_ff  <= rdv_ff && !prime_ff;
         bv_ff  <= av_ff;
      end
   end

   always_ff @(posedge clock) begin
      prime_ff <= cmd.rd_prime;
      if (rdv_ff) begin
         xj_ff <= x_rd;
         yj_ff <= y_rd;
      end
      straddle_a_ff <= straddle_in;
      dypos_a_ff    <= (dy_in > 0);
      dxp_ff        <= dxp_in;
      dy_ff         <= dy_in;
      dxe_ff        <= dxe_in;
      dyp_ff        <= dyp_in;
      straddle_b_ff <= straddle_a_ff;
      dypos_b_ff    <= dypos_a_ff;
      prod_p_ff     <= dxp_ff * dy_ff;
      prod_q_ff     <= dxe_ff * dyp_ff;
   end

   assign toggle = bv_ff && straddle_b_ff &&
                   (dypos_b_ff ? (prod_p_ff < prod_q_ff) : (prod_p_ff > prod_q_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
      end else if (cmd.clear_inside) begin
         inside_ff <= 1'b0;
      end else if (toggle) begin
         inside_ff <= !inside_ff;
      end
   end

   assign rsp_inside_res     = inside_ff;
   assign rsp_tested_polygon = poly_ff;

endmodule

// ===== src/point_in_polygon_test_top.sv =====
// Even-odd point-in-polygon tester for POLYGONS stored polygons of up to MAX_VERTICES
// vertices each. A transaction is accepted at a rising edge with start high and busy low.
// A load transaction writes one vertex and the polygon's vertex count; it gives no
// response and keeps busy high for one cycle. A query transaction walks every edge of
// the named polygon and gives one response, reached through the setup, walk, drain and
// respond states in that order; an empty or nonexistent polygon skips from setup
// straight to respond. The walk runs at one vertex per cycle, set by the single read
// port of the vertex memories, followed by a three-stage compare pipeline. The
// response appears for exactly one cycle with rsp_strobe high and cannot be held off
// by the receiver, so it must be captured in that cycle.
module point_in_polygon_test_top #(
   parameter int POLYGONS     = pip_pkg::POLYGONS_DEFAULT,
   parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEFAULT,
   parameter int COORD_WIDTH  = pip_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  pip_pkg::command_type                   req_command,
   input  logic [pip_pkg::POLY_ID_WIDTH-1:0]      req_polygon_id,
   input  logic [pip_pkg::VERTEX_INDEX_WIDTH-1:0] req_vertex_index,
   input  logic [pip_pkg::VERTEX_COUNT_WIDTH-1:0] req_vertex_count,
   input  logic [pip_pkg::COORD_PORT_WIDTH-1:0]   req_coord_x,
   input  logic [pip_pkg::COORD_PORT_WIDTH-1:0]   req_coord_y,
   output logic                                   rsp_strobe,
   output logic                                   rsp_inside_res,
   output logic [pip_pkg::POLY_ID_WIDTH-1:0]      rsp_tested_polygon
);

   localparam int VW = $clog2(MAX_VERTICES);
   localparam int CNTW = $clog2(MAX_VERTICES + 1);

   pip_pkg::ctrl_cmd_type  cmd;
   pip_pkg::ctrl_stat_type stat;
   logic [CNTW-1:0]        count;
   logic [VW-1:0]          rd_index;

   pip_ctrl #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .command    (req_command),
      .stat       (stat),
      .count      (count),
      .cmd        (cmd),
      .rd_index   (rd_index),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   pip_datapath #(
      .POLYGONS     (POLYGONS),
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_WIDTH  (COORD_WIDTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_polygon_id     (req_polygon_id),
      .req_vertex_index   (req_vertex_index),
      .req_vertex_count   (req_vertex_count),
      .req_coord_x        (req_coord_x),
      .req_coord_y        (req_coord_y),
      .cmd                (cmd),
      .rd_index           (rd_index),
      .stat               (stat),
      .count              (count),
      .rsp_inside_res     (rsp_inside_res),
      .rsp_tested_polygon (rsp_tested_polygon)
   );

   // A load transaction holds the block for one cycle and never produces a response.
   a_load_short: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command == pip_pkg::CMD_LOAD) |=> (busy && !rsp_strobe) ##1 !busy)
      else $error("load transaction did not complete in one cycle without response");

   // A query transaction never responds in the cycle right after acceptance.
   a_query_setup: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command == pip_pkg::CMD_QUERY) |=> (busy && !rsp_strobe))
      else $error("query transaction responded without walking the polygon");

   // The response ends the transaction and frees the block in the next cycle.
   a_rsp_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy ##1 (!busy && !rsp_strobe))
      else $error("response did not end the transaction");

   // The answered polygon is the one that was accepted with the query.
   a_rsp_poly: assert property (@(posedge clock) disable iff (reset)
      (busy && !rsp_strobe) |=> $stable(rsp_tested_polygon))
      else $error("tested polygon changed while a transaction was in progress");

endmodule

// ===== sim/pip_crossing_checker.sv =====
module pip_crossing_checker #(
   parameter int POLYGONS     = pip_pkg::POLYGONS_DEFAULT,
   parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic                                   busy,
   input  pip_pkg::command_type                   req_command,
   input  logic [pip_pkg::POLY_ID_WIDTH-1:0]      req_polygon_id,
   input  logic [pip_pkg::VERTEX_INDEX_WIDTH-1:0] req_vertex_index,
   input  logic [pip_pkg::VERTEX_COUNT_WIDTH-1:0] req_vertex_count,
   input  logic [pip_pkg::COORD_PORT_WIDTH-1:0]   req_coord_x,
   input  logic [pip_pkg::COORD_PORT_WIDTH-1:0]   req_coord_y,
   input  logic                                   rsp_strobe,
   input  logic                                   rsp_inside_res,
   input  logic [pip_pkg::POLY_ID_WIDTH-1:0]      rsp_tested_polygon,
   output int unsigned                            answers_pending,
   output int unsigned                            fail_count
);
   import pip_pkg::*;

   typedef struct packed {
      logic                     in_poly;
      logic [POLY_ID_WIDTH-1:0] polygon;
   } answer_type;

   logic signed [COORD_PORT_WIDTH-1:0] corner_x [POLYGONS*MAX_VERTICES];
   logic signed [COORD_PORT_WIDTH-1:0] corner_y [POLYGONS*MAX_VERTICES];
   int unsigned                        corner_count [POLYGONS];
   answer_type                         answers_due [$];

   initial fail_count = 0;
   initial answers_pending = 0;

   // Even-odd ray test with the crossing compare done on exact cross products.
   function automatic logic ray_parity(int unsigned poly,
                                       logic signed [COORD_PORT_WIDTH-1:0] px,
                                       logic signed [COORD_PORT_WIDTH-1:0] py);
      int unsigned                        n;
      int unsigned                        base;
      int unsigned                        j;
      logic signed [COORD_PORT_WIDTH-1:0] xi, yi, xj, yj;
      logic signed [COORD_PORT_WIDTH+1:0] rise, run, off_x, off_y;
      logic signed [2*COORD_PORT_WIDTH+3:0] lhs, rhs;
      logic                               parity;
      n = corner_count[poly];
      base = poly * MAX_VERTICES;
      parity = 1'b0;
      for (int unsigned i = 0; i < n; i++) begin
         j = (i == 0) ? n - 1 : i - 1;
         xi = corner_x[base + i];
         yi = corner_y[base + i];
         xj = corner_x[base + j];
         yj = corner_y[base + j];
         if ((yi > py) != (yj > py)) begin
            rise = yj - yi;
            run = xj - xi;
            off_x = px - xi;
            off_y = py - yi;
            lhs = off_x * rise;
            rhs = run * off_y;
            if ((rise > 0 && lhs < rhs) || (rise < 0 && lhs > rhs))
               parity = ~parity;
         end
      end
      return parity;
   endfunction

   always @(posedge clock) begin
      answer_type due;
      if (reset) begin
         for (int p = 0; p < POLYGONS; p++)
            corner_count[p] = 0;
         answers_due.delete();
      end else begin
         if (rsp_strobe) begin
            if (answers_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected result inside=%0b polygon=%0d", $time,
                           rsp_inside_res, rsp_tested_polygon);
            end else begin
               due = answers_due.pop_front();
               if (rsp_inside_res !== due.in_poly || rsp_tested_polygon !== due.polygon) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: expected inside=%0b polygon=%0d, got inside=%0b polygon=%0d",
                              $time, due.in_poly, due.polygon, rsp_inside_res,
                              rsp_tested_polygon);
               end
            end
         end
         if (start && !busy) begin
            if (req_command == CMD_LOAD) begin
               if (req_polygon_id < POLYGONS) begin
                  corner_count[req_polygon_id] = (req_vertex_count > MAX_VERTICES) ?
                                                 MAX_VERTICES : req_vertex_count;
                  if (req_vertex_index < MAX_VERTICES) begin
                     corner_x[req_polygon_id*MAX_VERTICES + req_vertex_index] = req_coord_x;
                     corner_y[req_polygon_id*MAX_VERTICES + req_vertex_index] = req_coord_y;
                  end
               end
            end else begin
               due.polygon = req_polygon_id;
               due.in_poly = (req_polygon_id < POLYGONS) ?
                             ray_parity(req_polygon_id, req_coord_x, req_coord_y) : 1'b0;
               answers_due.push_back(due);
            end
         end
      end
      answers_pending = answers_due.size();
   end

endmodule

// ===== sim/point_in_polygon_test_top_tb.sv =====
module point_in_polygon_test_top_tb;
   import pip_pkg::*;

   localparam int CLOCK_PERIOD  = 20;
   localparam int POLYGONS      = POLYGONS_DEFAULT;
   localparam int MAX_VERTICES  = MAX_VERTICES_DEFAULT;
   localparam int ITEM_GOAL     = 1000;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 100;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   command_type                   req_command = CMD_LOAD;
   logic [POLY_ID_WIDTH-1:0]      req_polygon_id = '0;
   logic [VERTEX_INDEX_WIDTH-1:0] req_vertex_index = '0;
   logic [VERTEX_COUNT_WIDTH-1:0] req_vertex_count = '0;
   logic [COORD_PORT_WIDTH-1:0]   req_coord_x = '0;
   logic [COORD_PORT_WIDTH-1:0]   req_coord_y = '0;
   logic                          rsp_strobe;
   logic                          rsp_inside_res;
   logic [POLY_ID_WIDTH-1:0]      rsp_tested_polygon;
   int unsigned                   answers_pending;
   int unsigned                   fail_count;
   int unsigned                   cycle_count = 0;
   int unsigned                   items_sent = 0;

   logic [COORD_PORT_WIDTH-1:0] shape_x [POLYGONS][MAX_VERTICES];
   logic [COORD_PORT_WIDTH-1:0] shape_y [POLYGONS][MAX_VERTICES];
   bit [MAX_VERTICES-1:0]       loaded_mask [POLYGONS];
   int unsigned                 shape_size [POLYGONS];

   point_in_polygon_test_top u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_polygon_id     (req_polygon_id),
      .req_vertex_index   (req_vertex_index),
      .req_vertex_count   (req_vertex_count),
      .req_coord_x        (req_coord_x),
      .req_coord_y        (req_coord_y),
      .rsp_strobe         (rsp_strobe),
      .rsp_inside_res     (rsp_inside_res),
      .rsp_tested_polygon (rsp_tested_polygon)
   );

   pip_crossing_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_polygon_id     (req_polygon_id),
      .req_vertex_index   (req_vertex_index),
      .req_vertex_count   (req_vertex_count),
      .req_coord_x        (req_coord_x),
      .req_coord_y        (req_coord_y),
      .rsp_strobe         (rsp_strobe),
      .rsp_inside_res     (rsp_inside_res),
      .rsp_tested_polygon (rsp_tested_polygon),
      .answers_pending    (answers_pending),
      .fail_count         (fail_count)
   );

   always #(CLOCK_PERIOD/2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic send(command_type cmd, int unsigned poly, int unsigned index,
                       int unsigned count, logic [31:0] x, logic [31:0] y);
      int unsigned idle_pct;
      idle_pct = (items_sent < ITEM_GOAL/3) ? 10 : (items_sent < 2*ITEM_GOAL/3) ? 57 : 0;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_command <= cmd;
      req_polygon_id <= POLY_ID_WIDTH'(poly);
      req_vertex_index <= VERTEX_INDEX_WIDTH'(index);
      req_vertex_count <= VERTEX_COUNT_WIDTH'(count);
      req_coord_x <= x;
      req_coord_y <= y;
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   task automatic load_vertex(int unsigned poly, int unsigned index, int unsigned count,
                              logic [31:0] x, logic [31:0] y);
      send(CMD_LOAD, poly, index, count, x, y);
      shape_size[poly] = (count > MAX_VERTICES) ? MAX_VERTICES : count;
      loaded_mask[poly][index] = 1'b1;
      shape_x[poly][index] = x;
      shape_y[poly][index] = y;
   endtask

   task automatic query(int unsigned poly, logic [31:0] x, logic [31:0] y);
      send(CMD_QUERY, poly, $urandom_range(MAX_VERTICES-1), $urandom_range(127), x, y);
   endtask

   function automatic bit fully_loaded(int unsigned poly);
      for (int unsigned i = 0; i < shape_size[poly]; i++)
         if (!loaded_mask[poly][i])
            return 1'b0;
      return 1'b1;
   endfunction

   function automatic int unsigned span_bits();
      case ($urandom_range(4))
         0: return 3;
         1: return 8;
         2: return 16;
         3: return 28;
         default: return 32;
      endcase
   endfunction

   function automatic int unsigned pick_size();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 4)
         return MAX_VERTICES;
      else if (r < 10)
         return $urandom_range(11, MAX_VERTICES-1);
      else if (r < 14)
         return $urandom_range(1, 2);
      return $urandom_range(3, 10);
   endfunction

   function automatic logic [31:0] near(logic [31:0] base, int unsigned span);
      logic signed [31:0] offset;
      offset = $signed($urandom) >>> (32 - span);
      return base + offset;
   endfunction

   task automatic build_polygon(int unsigned poly, int unsigned n, logic [31:0] base_x,
                                logic [31:0] base_y, int unsigned span);
      int unsigned count;
      for (int unsigned i = 0; i < n; i++) begin
         count = (n == MAX_VERTICES) ? $urandom_range(MAX_VERTICES, 127) : n;
         load_vertex(poly, i, count, near(base_x, span), near(base_y, span));
      end
   endtask

   task automatic probe(int unsigned poly, int unsigned span);
      int unsigned        n;
      int unsigned        k;
      int unsigned        j;
      logic [31:0]        base_x, base_y, x, y;
      logic signed [32:0] sum_x, sum_y;
      n = shape_size[poly];
      base_x = (n > 0) ? shape_x[poly][0] : $urandom;
      base_y = (n > 0) ? shape_y[poly][0] : $urandom;
      x = near(base_x, span);
      y = near(base_y, span);
      if (n > 0) begin
         k = $urandom_range(n - 1);
         j = (k == 0) ? n - 1 : k - 1;
         case ($urandom_range(5))
            3: begin
               x = shape_x[poly][k];
               y = shape_y[poly][k];
            end
            4: y = shape_y[poly][k];
            5: begin
               sum_x = $signed(shape_x[poly][k]) + $signed(shape_x[poly][j]);
               sum_y = $signed(shape_y[poly][k]) + $signed(shape_y[poly][j]);
               x = sum_x[32:1];
               y = sum_y[32:1];
            end
            default: ;
         endcase
      end
      query(poly, x, y);
   endtask

   initial begin
      int unsigned choice;
      int unsigned poly;
      int unsigned span;
      for (int p = 0; p < POLYGONS; p++) begin
         loaded_mask[p] = '0;
         shape_size[p] = 0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      query(0, 32'h8000_0000, 32'h7fff_ffff);
      load_vertex(1, 0, 4, -100, -100);
      load_vertex(1, 1, 4, 100, -100);
      load_vertex(1, 2, 4, 100, 100);
      load_vertex(1, 3, 4, -100, 100);
      query(1, 0, 0);
      query(1, 200, 0);
      query(1, -100, 0);
      query(1, 100, 0);
      query(1, 0, -100);
      query(1, -100, -100);
      load_vertex(15, 0, 3, 32'h8000_0000, 32'h8000_0000);
      load_vertex(15, 1, 3, 32'h7fff_ffff, 32'h8000_0000);
      load_vertex(15, 2, 3, 32'h0000_0000, 32'h7fff_ffff);
      query(15, 0, 0);
      query(15, 32'h7fff_ffff, 32'h7fff_ffff);
      query(15, 32'h8000_0000, 32'h8000_0000);
      load_vertex(14, MAX_VERTICES-1, 127, 32'hffff_ffff, 32'h0000_0001);
      load_vertex(14, 0, 1, 5, 5);
      query(14, 0, 5);
      load_vertex(1, 0, 0, -100, -100);
      query(1, 0, 0);

      while (items_sent < ITEM_GOAL) begin
         choice = $urandom_range(99);
         poly = $urandom_range(POLYGONS-1);
         if (choice < 55) begin
            span = span_bits();
            build_polygon(poly, pick_size(), $urandom, $urandom, span);
            repeat ($urandom_range(2, 6))
               probe(poly, span);
         end else if (choice < 85) begin
            if (fully_loaded(poly))
               probe(poly, span_bits());
         end else begin
            load_vertex(poly, $urandom_range(MAX_VERTICES-1), $urandom_range(127),
                        $urandom, $urandom);
         end
      end
      start <= 1'b0;

      while (answers_pending != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && answers_pending == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
